@@ rtl/siph_pkg.sv @@
package siph_pkg;

    localparam int WORD_W      = 64;
    localparam int BYTES_W     = 4;
    localparam int LEN_W       = 8;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 1'b1;

    localparam logic [WORD_W-1:0] IV0     = 64'h736f6d6570736575;
    localparam logic [WORD_W-1:0] IV1     = 64'h646f72616e646f6d;
    localparam logic [WORD_W-1:0] IV2     = 64'h6c7967656e657261;
    localparam logic [WORD_W-1:0] IV3     = 64'h7465646279746573;
    localparam logic [WORD_W-1:0] FIN_XOR = 64'h00000000000000ff;

    localparam logic [BYTES_W-1:0] FULL_BYTES = 4'd8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int FINAL_ROUNDS = 4;
    localparam int ROUND_CNT_W  = 2;

    typedef struct packed {
        logic [WORD_W-1:0] v0;
        logic [WORD_W-1:0] v1;
        logic [WORD_W-1:0] v2;
        logic [WORD_W-1:0] v3;
    } t_lanes;

    // One queued block: the word to absorb and whether finalisation follows.
    typedef struct packed {
        logic              fin;
        logic [WORD_W-1:0] data;
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ABSORB,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic pend;
    } t_front_stat;

    typedef struct packed {
        logic busy;
        logic finishing;
    } t_back_stat;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int r);
        return (x << r) | (x >> (WORD_W - r));
    endfunction

    function automatic t_lanes sip_round(input t_lanes v);
        t_lanes w;
        w = v;
        w.v0 = w.v0 + w.v1;
        w.v1 = rotl(w.v1, 13) ^ w.v0;
        w.v0 = rotl(w.v0, 32);
        w.v2 = w.v2 + w.v3;
        w.v3 = rotl(w.v3, 16) ^ w.v2;
        w.v0 = w.v0 + w.v3;
        w.v3 = rotl(w.v3, 21) ^ w.v0;
        w.v2 = w.v2 + w.v1;
        w.v1 = rotl(w.v1, 17) ^ w.v2;
        w.v2 = rotl(w.v2, 32);
        return w;
    endfunction

    function automatic t_lanes load_lanes(input logic [WORD_W-1:0] k0,
                                          input logic [WORD_W-1:0] k1);
        t_lanes w;
        w.v0 = k0 ^ IV0;
        w.v1 = k1 ^ IV1;
        w.v2 = k0 ^ IV2;
        w.v3 = k1 ^ IV3;
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] byte_mask(input logic [BYTES_W-1:0] n);
        logic [WORD_W-1:0] m;
        for (int i = 0; i < WORD_W / 8; i++) begin
            m[8*i +: 8] = (BYTES_W'(i) < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

@@ rtl/siphash_2_4_engine.sv @@
// The core runs one SipRound per cycle, but stalls while the output register still holds
// an unread hash; it takes a new block only once the last is absorbed, its lane registers
// are shared by all rounds, and a message ends with 4 more rounds for finalisation.
// Reset: synchronous, active low; the keys read as zero, queue and core are emptied, and
// the first message after reset starts from lanes loaded with the key held when it starts.
module siphash_2_4_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Message word requests.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [siph_pkg::WORD_W-1:0]       i_s_tdata,  // bits 63:0 message_word
    input  logic [siph_pkg::BYTES_W-1:0]      i_s_tuser,  // bits 3:0 valid_bytes
    input  logic                              i_s_tlast,  // last_word
    // Hash result requests.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [siph_pkg::WORD_W-1:0]       o_m_tdata,  // bits 63:0 hash_value
    // Key write requests.
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [siph_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [siph_pkg::WORD_W-1:0]       i_cfg_data
);
    import siph_pkg::*;

    logic [WORD_W-1:0] r_key_low;
    logic [WORD_W-1:0] r_key_high;

    logic        push_valid;
    logic        push_ready;
    t_cmd        push_cmd;
    logic        pop_valid;
    logic        pop;
    t_cmd        pop_cmd;
    t_front_stat front_stat;
    t_back_stat  back_stat;

    // Key writes are always taken. The core copies the key into its lanes only when
    // it starts a new message, so a write between two words of a message leaves the
    // running hash untouched and applies from the next message onwards.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                default:      r_key_low  <= r_key_low;
            endcase
        end
    end

    // The front end masks the tail bytes, keeps the running length and turns each
    // request into one queued block; a full last word yields a second block that
    // holds only the length byte, and the front end holds off input until it is queued.
    siph_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_q_valid  (push_valid),
        .i_q_ready  (push_ready),
        .o_q_cmd    (push_cmd),
        .o_stat     (front_stat)
    );

    // A two-entry queue lets the front end keep taking words while the core rounds.
    siph_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_valid),
        .o_ready (push_ready),
        .i_cmd   (push_cmd),
        .o_valid (pop_valid),
        .i_pop   (pop),
        .o_cmd   (pop_cmd)
    );

    // The core absorbs each block, runs the finalisation rounds after the last one and holds the
    // hash in its output register, stalling only when that register is still full.
    siph_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_low    (r_key_low),
        .i_key_high   (r_key_high),
        .i_q_valid    (pop_valid),
        .i_q_cmd      (pop_cmd),
        .o_q_pop      (pop),
        .o_hash_valid (o_m_tvalid),
        .i_hash_ready (i_m_tready),
        .o_hash       (o_m_tdata),
        .o_stat       (back_stat)
    );

`ifndef SYNTHESIS
    // The core only takes a block the queue actually holds.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> pop_valid)
        else $error("core popped an empty queue");

    // A new hash appears only after the last finalisation round.
    a_hash_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(back_stat.finishing))
        else $error("hash valid without finalisation");

    // While the length-only block is pending, no further word is taken.
    a_pend_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_stat.pend |-> !o_s_tready)
        else $error("input taken while a length block is pending");

    // A hash is only loaded while the core is busy finalising.
    a_finish_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_stat.finishing |-> back_stat.busy)
        else $error("hash loaded while core idle");
`endif

endmodule

@@ rtl/siph_front.sv @@
module siph_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [siph_pkg::WORD_W-1:0]   i_s_tdata,  // message_word
    input  logic [siph_pkg::BYTES_W-1:0]  i_s_tuser,  // valid_bytes
    input  logic                          i_s_tlast,  // last_word
    output logic                          o_q_valid,
    input  logic                          i_q_ready,
    output siph_pkg::t_cmd                o_q_cmd,
    output siph_pkg::t_front_stat         o_stat
);
    import siph_pkg::*;

    logic [LEN_W-1:0]   r_len,     n_len;
    logic               r_pend,    n_pend;
    logic [LEN_W-1:0]   r_pend_len, n_pend_len;
    logic [BYTES_W-1:0] nbytes;
    logic [LEN_W-1:0]   len_sum;
    logic               accept;

    assign o_s_tready = !r_pend && i_q_ready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_q_valid  = r_pend || i_s_tvalid;
    assign o_stat.pend = r_pend;

    // Non-last words, and counts above eight, count as full words.
    assign nbytes  = (!i_s_tlast || (i_s_tuser > FULL_BYTES)) ? FULL_BYTES : i_s_tuser;
    assign len_sum = r_len + LEN_W'(nbytes);

    always_comb begin
        n_len      = r_len;
        n_pend     = r_pend;
        n_pend_len = r_pend_len;
        o_q_cmd    = '0;
        if (r_pend) begin
            o_q_cmd.fin  = 1'b1;
            o_q_cmd.data = {r_pend_len, {(WORD_W - LEN_W){1'b0}}};
            if (i_q_ready) begin
                n_pend = 1'b0;
            end
        end else begin
            if (!i_s_tlast || (nbytes == FULL_BYTES)) begin
                o_q_cmd.fin  = 1'b0;
                o_q_cmd.data = i_s_tdata;
            end else begin
                o_q_cmd.fin  = 1'b1;
                o_q_cmd.data = (i_s_tdata & byte_mask(nbytes))
                             | {len_sum, {(WORD_W - LEN_W){1'b0}}};
            end
            if (accept) begin
                if (!i_s_tlast) begin
                    n_len = len_sum;
                end else begin
                    n_len = '0;
                    if (nbytes == FULL_BYTES) begin
                        // A full last word leaves a block of length only.
                        n_pend     = 1'b1;
                        n_pend_len = len_sum;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_len  <= n_len;
            r_pend <= n_pend;
        end
        r_pend_len <= n_pend_len;
    end

endmodule

@@ rtl/siph_fifo.sv @@
module siph_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_ready,
    input  siph_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_pop,
    output siph_pkg::t_cmd o_cmd
);
    import siph_pkg::*;

    t_cmd                   r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr, n_wr;
    logic [QUEUE_PTR_W-1:0] r_rd, n_rd;
    logic [QUEUE_CNT_W-1:0] r_count, n_count;
    logic                   push_ok;
    logic                   pop_ok;

    assign o_ready = (r_count != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign push_ok = i_push && o_ready;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count + QUEUE_CNT_W'(push_ok) - QUEUE_CNT_W'(pop_ok);
        if (push_ok) begin
            n_wr = (r_wr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
        if (push_ok) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

@@ rtl/siph_core.sv @@
module siph_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [siph_pkg::WORD_W-1:0] i_key_low,
    input  logic [siph_pkg::WORD_W-1:0] i_key_high,
    input  logic                        i_q_valid,
    input  siph_pkg::t_cmd              i_q_cmd,
    output logic                        o_q_pop,
    output logic                        o_hash_valid,
    input  logic                        i_hash_ready,
    output logic [siph_pkg::WORD_W-1:0] o_hash,
    output siph_pkg::t_back_stat        o_stat
);
    import siph_pkg::*;

    t_state                 r_state, n_state;
    logic [ROUND_CNT_W-1:0] r_cnt,   n_cnt;
    t_lanes                 r_lanes, n_lanes;
    logic [WORD_W-1:0]      r_m,     n_m;
    logic                   r_fin,   n_fin;
    logic                   r_fresh, n_fresh;
    logic                   r_out_valid, n_out_valid;
    logic [WORD_W-1:0]      r_hash,  n_hash;
    logic                   out_free;
    logic                   load_hash;
    t_lanes                 base;
    t_lanes                 rnd;

    assign out_free     = !r_out_valid || i_hash_ready;
    assign o_hash_valid = r_out_valid;
    assign o_hash       = r_hash;
    assign o_stat.busy      = (r_state != ST_IDLE);
    assign o_stat.finishing = load_hash;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_state = ST_ABSORB;
                end
            end
            ST_ABSORB: begin
                n_state = r_fin ? ST_FINAL : ST_IDLE;
            end
            ST_FINAL: begin
                if ((r_cnt == '0) && out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_cnt     = r_cnt;
        n_lanes   = r_lanes;
        n_m       = r_m;
        n_fin     = r_fin;
        n_fresh   = r_fresh;
        n_hash    = r_hash;
        o_q_pop   = 1'b0;
        load_hash = 1'b0;
        base      = r_fresh ? load_lanes(i_key_low, i_key_high) : r_lanes;
        base.v3   = base.v3 ^ i_q_cmd.data;
        rnd       = sip_round(r_lanes);
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_lanes = sip_round(base);
                    n_m     = i_q_cmd.data;
                    n_fin   = i_q_cmd.fin;
                    n_fresh = 1'b0;
                end
            end
            ST_ABSORB: begin
                n_lanes    = rnd;
                n_lanes.v0 = rnd.v0 ^ r_m;
                if (r_fin) begin
                    n_lanes.v2 = rnd.v2 ^ FIN_XOR;
                end
                n_cnt = ROUND_CNT_W'(FINAL_ROUNDS - 1);
            end
            ST_FINAL: begin
                if (r_cnt != '0) begin
                    n_lanes = rnd;
                    n_cnt   = r_cnt - 1'b1;
                end else if (out_free) begin
                    load_hash = 1'b1;
                    n_hash    = rnd.v0 ^ rnd.v1 ^ rnd.v2 ^ rnd.v3;
                    n_fresh   = 1'b1;
                end
            end
            default: begin
                n_lanes = r_lanes;
            end
        endcase
        if (load_hash) begin
            n_out_valid = 1'b1;
        end else if (i_hash_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_fresh     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
        r_lanes <= n_lanes;
        r_m     <= n_m;
        r_fin   <= n_fin;
        r_hash  <= n_hash;
    end

endmodule
